[rtl/pgh_pkg.sv]
// shared constants and types for the horizontal prewitt gradient block
`default_nettype none
package pgh_pkg;

   localparam int MAX_LINE_PIXELS = 1024;
   localparam int COL_W           = $clog2(MAX_LINE_PIXELS);
   localparam int WIDTH_W         = 11;
   localparam int HEIGHT_W        = 16;
   localparam int CSR_DATA_W      = 16;
   localparam int CSR_INDEX_W     = 2;
   localparam int PIX_W           = 24;
   localparam int CHAN_W          = 8;
   localparam int NUM_CHAN        = 3;
   localparam int SUM_W           = 10;
   localparam int LINE_DATA_W     = 2 * PIX_W;

   // floor(x / 3) == (x * 683) >> 11 for every x up to 765
   localparam int RECIP_3_W       = 10;
   localparam int RECIP_3_SHIFT   = 11;
   localparam logic [RECIP_3_W-1:0] RECIP_3 = RECIP_3_W'(683);
   localparam int PROD_W          = SUM_W + RECIP_3_W;

   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 3);

   localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_LINE_PIXELS);
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1
   } reg_index_type;

   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_col_type;

   typedef struct packed {
      logic                   en;
      logic [COL_W-1:0]       addr;
      logic [LINE_DATA_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
   } mem_rd_type;

endpackage
`default_nettype wire

[rtl/pgh_line_buffer.sv]
// two line stores held side by side in one memory, registered read
`default_nettype none
module pgh_line_buffer (
   input  wire                                clock,
   input  pgh_pkg::mem_rd_type                rd,
   input  pgh_pkg::mem_wr_type                wr,
   output logic [pgh_pkg::LINE_DATA_W-1:0]    rd_data
);

   // upper line in the low half, middle line in the high half
   logic [pgh_pkg::LINE_DATA_W-1:0] mem_ff [pgh_pkg::MAX_LINE_PIXELS];
   logic [pgh_pkg::LINE_DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/pgh_lane.sv]
// one colour channel: column sums, absolute difference and divide by three
`default_nettype none
module pgh_lane (
   input  wire                          clock,
   input  wire                          load,
   input  pgh_pkg::chan_col_type        right_col,
   input  pgh_pkg::chan_col_type        left_col,
   output logic [pgh_pkg::CHAN_W-1:0]   grad
);

   logic [pgh_pkg::SUM_W-1:0]  rsum_in, lsum_in, rsum_ff, lsum_ff;
   logic [pgh_pkg::SUM_W-1:0]  mag;
   logic [pgh_pkg::PROD_W-1:0] prod;

   always_comb begin
      rsum_in = pgh_pkg::SUM_W'(right_col[0]) + pgh_pkg::SUM_W'(right_col[1])
              + pgh_pkg::SUM_W'(right_col[2]);
      lsum_in = pgh_pkg::SUM_W'(left_col[0]) + pgh_pkg::SUM_W'(left_col[1])
              + pgh_pkg::SUM_W'(left_col[2]);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsum_ff <= rsum_in;
         lsum_ff <= lsum_in;
      end
   end

   always_comb begin
      mag  = (rsum_ff >= lsum_ff) ? (rsum_ff - lsum_ff) : (lsum_ff - rsum_ff);
      prod = pgh_pkg::PROD_W'(mag) * pgh_pkg::PROD_W'(pgh_pkg::RECIP_3);
      grad = prod[pgh_pkg::RECIP_3_SHIFT +: pgh_pkg::CHAN_W];
   end

endmodule
`default_nettype wire

[rtl/prewitt_horizontal_gradient_rgb.sv]
// horizontal prewitt gradient over rgb pixels in raster order
// path: the line-store read goes with the pixel transfer, then the column sums are
//   registered and the divided result is written into the output queue
// throughput: one pixel per cycle when not stalled (one line-store read, one write)
// reset: synchronous, clears positions and window, loads 640 x 480; line stores
//   are not cleared and no clearing pass runs
`default_nettype none
module prewitt_horizontal_gradient_rgb (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [pgh_pkg::CHAN_W-1:0]           req_red_in,
   input  wire  [pgh_pkg::CHAN_W-1:0]           req_green_in,
   input  wire  [pgh_pkg::CHAN_W-1:0]           req_blue_in,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [pgh_pkg::CHAN_W-1:0]           rsp_red_grad,
   output logic [pgh_pkg::CHAN_W-1:0]           rsp_green_grad,
   output logic [pgh_pkg::CHAN_W-1:0]           rsp_blue_grad,
   output logic                                 rsp_frame_last,
   input  wire                                  csr_wr_en,
   input  wire  [pgh_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [pgh_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int RES_W = pgh_pkg::NUM_CHAN * pgh_pkg::CHAN_W + 1;

   // configuration and position
   logic [pgh_pkg::WIDTH_W-1:0]  width_ff;
   logic [pgh_pkg::HEIGHT_W-1:0] height_ff;
   logic [pgh_pkg::WIDTH_W-1:0]  width_eff;
   logic [pgh_pkg::HEIGHT_W-1:0] height_eff;
   logic [pgh_pkg::COL_W-1:0]    col_last;
   logic [pgh_pkg::HEIGHT_W-1:0] row_last;
   logic [pgh_pkg::COL_W-1:0]    col_ff;
   logic [pgh_pkg::HEIGHT_W-1:0] row_ff;
   logic                         accept;
   logic                         emit;
   logic                         last;

   // stage 1: line-store data returns
   logic                         s1_valid_ff, s1_emit_ff, s1_last_ff;
   logic [pgh_pkg::PIX_W-1:0]    s1_px_ff;
   logic [pgh_pkg::COL_W-1:0]    s1_col_ff;
   logic [pgh_pkg::PIX_W-1:0]    center_ff [3];
   logic [pgh_pkg::PIX_W-1:0]    left_ff [3];
   logic [pgh_pkg::PIX_W-1:0]    right_col [3];
   logic [pgh_pkg::LINE_DATA_W-1:0] line_rd;
   pgh_pkg::mem_rd_type          mem_rd;
   pgh_pkg::mem_wr_type          mem_wr;

   // stage 2: lane sums held
   logic                         s2_valid_ff, s2_last_ff;
   logic [pgh_pkg::CHAN_W-1:0]   lane_grad [pgh_pkg::NUM_CHAN];

   // output queue
   logic [RES_W-1:0]             fifo_ff [pgh_pkg::FIFO_DEPTH];
   logic [pgh_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [pgh_pkg::FIFO_CNT_W-1:0] fifo_count_ff, fifo_count_in, inflight;
   logic                         push, pop;
   logic [RES_W-1:0]             fifo_rd;

   always_comb begin
      if (width_ff < pgh_pkg::WIDTH_MIN) begin
         width_eff = pgh_pkg::WIDTH_MIN;
      end else if (width_ff > pgh_pkg::WIDTH_MAX) begin
         width_eff = pgh_pkg::WIDTH_MAX;
      end else begin
         width_eff = width_ff;
      end
      height_eff = (height_ff < pgh_pkg::HEIGHT_MIN) ? pgh_pkg::HEIGHT_MIN : height_ff;
      col_last   = pgh_pkg::COL_W'(width_eff - pgh_pkg::WIDTH_W'(1));
      row_last   = height_eff - pgh_pkg::HEIGHT_W'(1);
   end

   assign accept = req_valid && !req_stall;
   assign emit   = (row_ff >= pgh_pkg::HEIGHT_W'(2)) && (col_ff >= pgh_pkg::COL_W'(2));
   assign last   = (row_ff == row_last) && (col_ff == col_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pgh_pkg::WIDTH_RESET;
         height_ff <= pgh_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_wr_en) begin
         // any known register write restarts the frame
         case (csr_index)
            pgh_pkg::REG_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[pgh_pkg::WIDTH_W-1:0];
               col_ff   <= '0;
               row_ff   <= '0;
            end
            pgh_pkg::REG_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[pgh_pkg::HEIGHT_W-1:0];
               col_ff    <= '0;
               row_ff    <= '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (col_ff >= col_last) begin
            col_ff <= '0;
            row_ff <= (row_ff >= row_last) ? '0 : row_ff + pgh_pkg::HEIGHT_W'(1);
         end else begin
            col_ff <= col_ff + pgh_pkg::COL_W'(1);
         end
      end
   end

   assign mem_rd.en   = accept;
   assign mem_rd.addr = col_ff;

   pgh_line_buffer u_line_buffer (
      .clock   (clock),
      .rd      (mem_rd),
      .wr      (mem_wr),
      .rd_data (line_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_emit_ff  <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= {req_blue_in, req_green_in, req_red_in};
         s1_col_ff  <= col_ff;
         s1_last_ff <= last;
      end
   end

   assign right_col[0] = line_rd[pgh_pkg::PIX_W-1:0];
   assign right_col[1] = line_rd[pgh_pkg::LINE_DATA_W-1:pgh_pkg::PIX_W];
   assign right_col[2] = s1_px_ff;

   // middle line moves up, new pixel becomes the middle line
   assign mem_wr.en   = s1_valid_ff;
   assign mem_wr.addr = s1_col_ff;
   assign mem_wr.data = {s1_px_ff, right_col[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            center_ff[i] <= '0;
            left_ff[i]   <= '0;
         end
      end else if (s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            left_ff[i]   <= center_ff[i];
            center_ff[i] <= right_col[i];
         end
      end
   end

   for (genvar k = 0; k < pgh_pkg::NUM_CHAN; k++) begin : g_lane
      pgh_pkg::chan_col_type lane_right, lane_left;
      for (genvar i = 0; i < 3; i++) begin : g_tap
         assign lane_right[i] = right_col[i][k*pgh_pkg::CHAN_W +: pgh_pkg::CHAN_W];
         assign lane_left[i]  = left_ff[i][k*pgh_pkg::CHAN_W +: pgh_pkg::CHAN_W];
      end
      pgh_lane u_lane (
         .clock     (clock),
         .load      (s1_emit_ff),
         .right_col (lane_right),
         .left_col  (lane_left),
         .grad      (lane_grad[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_emit_ff) begin
         s2_last_ff <= s1_last_ff;
      end
   end

   // merge the lanes into the output queue
   assign push    = s2_valid_ff;
   assign pop     = rsp_valid && !rsp_stall;
   assign fifo_rd = fifo_ff[rd_ptr_ff];

   always_comb begin
      fifo_count_in = fifo_count_ff;
      if (push && !pop) begin
         fifo_count_in = fifo_count_ff + pgh_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         fifo_count_in = fifo_count_ff - pgh_pkg::FIFO_CNT_W'(1);
      end
      // reserve room for every result still in the pipeline
      inflight = fifo_count_ff + pgh_pkg::FIFO_CNT_W'(s1_emit_ff)
               + pgh_pkg::FIFO_CNT_W'(s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= {s2_last_ff, lane_grad[2], lane_grad[1], lane_grad[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         fifo_count_ff <= fifo_count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + pgh_pkg::FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + pgh_pkg::FIFO_PTR_W'(1);
         end
      end
   end

   assign req_stall      = inflight >= pgh_pkg::FIFO_CNT_W'(pgh_pkg::FIFO_DEPTH);
   assign rsp_valid      = fifo_count_ff != '0;
   assign rsp_red_grad   = fifo_rd[pgh_pkg::CHAN_W-1:0];
   assign rsp_green_grad = fifo_rd[2*pgh_pkg::CHAN_W-1:pgh_pkg::CHAN_W];
   assign rsp_blue_grad  = fifo_rd[3*pgh_pkg::CHAN_W-1:2*pgh_pkg::CHAN_W];
   assign rsp_frame_last = fifo_rd[RES_W-1];

`ifndef SYNTH
   // the queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && fifo_count_ff == pgh_pkg::FIFO_CNT_W'(pgh_pkg::FIFO_DEPTH)))
      else $error("output queue overflow");

   // line-store write never lands on the column being read
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff) |-> (col_ff != s1_col_ff))
      else $error("line store read and write at the same column");

   // every result in the lanes reaches the queue on the next cycle
   a_lane_to_queue: assert property (@(posedge clock) disable iff (reset)
      s1_emit_ff |=> push)
      else $error("lane result lost before the output queue");

   // queue occupancy stays within its depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= pgh_pkg::FIFO_CNT_W'(pgh_pkg::FIFO_DEPTH))
      else $error("output queue count out of range");
`endif

endmodule
`default_nettype wire

[tb/prewitt_horizontal_gradient_rgb_tb.sv]
// self-checking testbench for the horizontal prewitt gradient block over rgb raster streams
`default_nettype none
module prewitt_horizontal_gradient_rgb_tb;
   import pgh_pkg::*;

   localparam int RESET_CYCLES      = 7;
   localparam int SETTLE_CYCLES     = 8;
   localparam int REPORT_LIMIT      = 10;
   localparam int LONG_HOLD_CYCLES  = 400;
   localparam int LONG_HOLD_MARK    = 40;
   localparam int DRAIN_LIMIT       = 20000;
   localparam int NUM_GEOMETRIES    = 10;
   localparam int RESET_LINE_PIXELS = 40;
   localparam int PRESS_WIDTH       = 24;
   localparam int PRESS_HEIGHT      = 12;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              frame_last;
   } grad_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   wire                    req_stall;
   logic [CHAN_W-1:0]      req_red_in = '0;
   logic [CHAN_W-1:0]      req_green_in = '0;
   logic [CHAN_W-1:0]      req_blue_in = '0;
   wire                    rsp_valid;
   logic                   rsp_stall = 1'b0;
   wire  [CHAN_W-1:0]      rsp_red_grad;
   wire  [CHAN_W-1:0]      rsp_green_grad;
   wire  [CHAN_W-1:0]      rsp_blue_grad;
   wire                    rsp_frame_last;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   prewitt_horizontal_gradient_rgb dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_grad   (rsp_red_grad),
      .rsp_green_grad (rsp_green_grad),
      .rsp_blue_grad  (rsp_blue_grad),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted copy of the block state
   chan_col_type          upper_line [MAX_LINE_PIXELS];
   chan_col_type          middle_line [MAX_LINE_PIXELS];
   chan_col_type          win_centre [3];
   chan_col_type          win_left [3];
   int                    col_pos;
   int                    row_pos;
   logic [WIDTH_W-1:0]    width_reg;
   logic [HEIGHT_W-1:0]   height_reg;

   chan_col_type pixel_pending [$];
   grad_result_type grad_expected [$];
   int pixels_queued = 0;
   int pixels_sent = 0;
   int grads_seen = 0;
   int grad_mismatches = 0;
   int stalled_offers = 0;
   int reg_writes = 0;
   int send_calm = 0;
   int recv_calm = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit long_hold_done = 1'b0;

   function automatic int line_pixels();
      if (width_reg < WIDTH_MIN) return int'(WIDTH_MIN);
      if (width_reg > WIDTH_MAX) return int'(WIDTH_MAX);
      return int'(width_reg);
   endfunction

   function automatic int frame_lines();
      return (height_reg < HEIGHT_MIN) ? int'(HEIGHT_MIN) : int'(height_reg);
   endfunction

   task automatic clear_prediction();
      int i;
      for (i = 0; i < MAX_LINE_PIXELS; i++) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
      end
      for (i = 0; i < 3; i++) begin
         win_centre[i] = '0;
         win_left[i] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
   endtask

   task automatic grad_predict(input chan_col_type px);
      int w, h, c, r, k, rs, ls, mag;
      chan_col_type right [3];
      chan_col_type quot;
      grad_result_type res;
      w = line_pixels();
      h = frame_lines();
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = row_pos;
      right[0] = upper_line[c];
      right[1] = middle_line[c];
      right[2] = px;
      upper_line[c] = middle_line[c];
      middle_line[c] = px;
      if (r >= 2 && c >= 2) begin
         for (k = 0; k < NUM_CHAN; k++) begin
            rs = int'(right[0][k]) + int'(right[1][k]) + int'(right[2][k]);
            ls = int'(win_left[0][k]) + int'(win_left[1][k]) + int'(win_left[2][k]);
            mag = (rs >= ls) ? rs - ls : ls - rs;
            quot[k] = CHAN_W'(mag / 3);
         end
         res = {quot[0], quot[1], quot[2], (r == h - 1 && c == w - 1)};
         grad_expected.push_back(res);
      end
      for (k = 0; k < 3; k++) begin
         win_left[k] = win_centre[k];
         win_centre[k] = right[k];
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   // idle lengths: mostly none or short, a few long, and now and then a calm stretch
   task automatic draw_idle(inout int calm, output int len);
      int pick;
      len = 0;
      if (calm > 0) begin
         calm--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 3) calm = $urandom_range(30, 120);
         else if (pick < 55) len = 0;
         else if (pick < 88) len = $urandom_range(1, 3);
         else if (pick < 97) len = $urandom_range(4, 12);
         else len = $urandom_range(20, 40);
      end
   endtask

   function automatic chan_col_type random_pixel();
      chan_col_type px;
      int k;
      for (k = 0; k < NUM_CHAN; k++) begin
         case ($urandom_range(0, 9))
            0:       px[k] = '0;
            1:       px[k] = '1;
            default: px[k] = CHAN_W'($urandom);
         endcase
      end
      return px;
   endfunction

   task automatic push_pixel(input chan_col_type px);
      pixel_pending.push_back(px);
      pixels_queued++;
   endtask

   task automatic push_random(input int count);
      int i;
      for (i = 0; i < count; i++) push_pixel(random_pixel());
   endtask

   task automatic wait_drained();
      while (pixels_sent != pixels_queued || grad_expected.size() != 0) @(posedge clock);
      // pixels that raise no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      reg_writes++;
      case (idx)
         REG_IMAGE_WIDTH: begin
            width_reg = value[WIDTH_W-1:0];
            col_pos = 0;
            row_pos = 0;
         end
         REG_IMAGE_HEIGHT: begin
            height_reg = value[HEIGHT_W-1:0];
            col_pos = 0;
            row_pos = 0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : drive_pixels
      chan_col_type px;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_stall) stalled_offers++;
         if (req_valid && !req_stall) begin
            grad_predict({req_blue_in, req_green_in, req_red_in});
            pixels_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_pending.size() > 0) begin
               px = pixel_pending.pop_front();
               req_red_in <= px[0];
               req_green_in <= px[1];
               req_blue_in <= px[2];
               req_valid <= 1'b1;
               draw_idle(send_calm, gap_left);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_results
      grad_result_type got;
      grad_result_type want;
      int len;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if ($isunknown(rsp_valid)) begin
            grad_mismatches++;
            if (grad_mismatches <= REPORT_LIMIT) $display("rsp_valid unknown");
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_red_grad, rsp_green_grad, rsp_blue_grad, rsp_frame_last};
            grads_seen++;
            if (grad_expected.size() == 0) begin
               grad_mismatches++;
               if (grad_mismatches <= REPORT_LIMIT)
                  $display("result %0d arrived with none expected: r=%0d g=%0d b=%0d last=%0b",
                           grads_seen, got.red, got.green, got.blue, got.frame_last);
            end else begin
               want = grad_expected.pop_front();
               if (got !== want) begin
                  grad_mismatches++;
                  if (grad_mismatches <= REPORT_LIMIT)
                     $display("result %0d: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                              grads_seen, want.red, want.green, want.blue, want.frame_last,
                              got.red, got.green, got.blue, got.frame_last);
               end
            end
         end
         // one long hold-off so the block backs up into its input
         if (!long_hold_done && grads_seen >= LONG_HOLD_MARK) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            draw_idle(recv_calm, len);
            rsp_stall <= (len > 0);
            stall_left = (len > 0) ? len - 1 : 0;
         end
      end
   end

   initial begin : stimulus
      int i, s, f, w, h, split, n;
      logic [WIDTH_W-1:0]  wraw;
      logic [HEIGHT_W-1:0] hraw;
      logic [4:0]          junk;
      chan_col_type        px;

      clear_prediction();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: part of the first line, too early for any result
      push_random(RESET_LINE_PIXELS);
      wait_drained();

      // 3x3 frames from clamped registers, one after another across the wrap
      write_reg(REG_IMAGE_WIDTH, 16'h0000);
      write_reg(REG_IMAGE_HEIGHT, 16'h0002);
      for (i = 0; i < 9; i++) begin
         case (i % 3)
            0:       px = {8'h55, 8'hFF, 8'h00};
            2:       px = {8'h55, 8'h00, 8'hFF};
            default: px = {8'h80, 8'h80, 8'h80};
         endcase
         push_pixel(px);
      end
      for (i = 0; i < 9; i++) begin
         case (i % 3)
            0:       px = {8'hFF, 8'hFF, 8'hFF};
            2:       px = {8'h00, 8'h00, 8'h00};
            default: px = random_pixel();
         endcase
         push_pixel(px);
      end
      wait_drained();

      // a frame long enough for the receiver hold to back up into the input
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(PRESS_WIDTH));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(PRESS_HEIGHT));
      push_random(PRESS_WIDTH * PRESS_HEIGHT);
      wait_drained();

      for (s = 0; s < NUM_GEOMETRIES; s++) begin
         case (s)
            0: begin
               wraw = 11'd1;
               hraw = 16'd0;
            end
            1: begin
               wraw = 11'd3;
               hraw = 16'hFFFF;
            end
            2: begin
               wraw = 11'd2;
               hraw = 16'd1;
            end
            default: begin
               wraw = WIDTH_W'($urandom_range(3, 12));
               hraw = HEIGHT_W'($urandom_range(3, 6));
            end
         endcase
         junk = 5'($urandom);
         if ($urandom_range(0, 1)) begin
            write_reg(REG_IMAGE_WIDTH, {junk, wraw});
            write_reg(REG_IMAGE_HEIGHT, hraw);
         end else begin
            write_reg(REG_IMAGE_HEIGHT, hraw);
            write_reg(REG_IMAGE_WIDTH, {junk, wraw});
         end
         w = line_pixels();
         h = frame_lines();
         if (hraw == 16'hFFFF) begin
            push_random(5 * w);
         end else begin
            for (f = $urandom_range(1, 3); f > 0; f--) begin
               if ($urandom_range(0, 3) == 0) begin
                  // pause mid-frame until everything is out, maybe poke an unused index
                  split = $urandom_range(1, w * h - 1);
                  push_random(split);
                  wait_drained();
                  if ($urandom_range(0, 1))
                     write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                               CSR_DATA_W'($urandom));
                  push_random(w * h - split);
               end else begin
                  push_random(w * h);
               end
            end
            // a partial frame left for the next register write to cut short
            if ($urandom_range(0, 1)) push_random($urandom_range(1, w * h - 1));
         end
         wait_drained();
      end

      n = 0;
      while ((pixels_sent != pixels_queued || grad_expected.size() != 0) && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pixels_sent != pixels_queued || grad_expected.size() != 0) begin
         grad_mismatches++;
         $display("%0d pixels never accepted, %0d results never arrived",
                  pixels_queued - pixels_sent, grad_expected.size());
      end
      $display("sent %0d pixels through %0d register writes, checked %0d gradients",
               pixels_sent, reg_writes, grads_seen);
      $display("input held back on %0d offered cycles, one receiver hold of %0d cycles",
               stalled_offers, LONG_HOLD_CYCLES);
      if (grad_mismatches == 0) begin
         $display("prewitt_horizontal_gradient_rgb: match");
      end else begin
         $display("prewitt_horizontal_gradient_rgb: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("prewitt_horizontal_gradient_rgb: mismatch");
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
rtl/pgh_pkg.sv
rtl/pgh_line_buffer.sv
rtl/pgh_lane.sv
rtl/prewitt_horizontal_gradient_rgb.sv
tb/prewitt_horizontal_gradient_rgb_tb.sv
